/* src/vtx_command_framer_assert.svh */
// vtx_command_framer_assert.svh: assertion macros for the command framer checkers.
// No dependencies; included by the checker file.
`ifndef VTX_COMMAND_FRAMER_ASSERT_SVH
`define VTX_COMMAND_FRAMER_ASSERT_SVH

// property checked while out of reset
`define VCF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds across reset
`define VCF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/vcf_pkg.sv */
// vcf_pkg: frame constants, byte index type and CRC-8 (poly 0xD5) byte step.
// No dependencies; used by vtx_command_framer and its checker.
package vcf_pkg;

  localparam int FRAME_LEN = 7;

  typedef logic [2:0] idx_t;

  localparam idx_t IDX_CRC = 3'd6;

  localparam logic [7:0] SYNC_A        = 8'hAA;
  localparam logic [7:0] SYNC_B        = 8'h55;
  localparam logic [7:0] OP_FREQ       = 8'h04;
  localparam logic [7:0] OP_POWER      = 8'h02;
  localparam logic [7:0] FREQ_PLD_LEN  = 8'h02;
  localparam logic [7:0] POWER_PLD_LEN = 8'h03;
  localparam logic [7:0] POWER_SUB     = 8'h01;
  localparam logic [7:0] CRC_POLY      = 8'hD5;

  localparam logic [15:0] FREQ_MIN = 16'd5600;
  localparam logic [15:0] FREQ_MAX = 16'd5800;

  localparam logic CMD_POWER = 1'b0;
  localparam logic CMD_FREQ  = 1'b1;

  // one byte through the CRC, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] acc_in, input logic [7:0] data);
    logic [7:0] acc;
    acc = acc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

/* src/vtx_command_framer.sv */
// vtx_command_framer: builds a 7-byte command frame per item, CRC-8 appended.
// Depends on vcf_pkg.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+---------------------------
//   input   | in_command, in_value                   | start & !busy
//   result  | out_frame_byte, out_last               | out_valid, one cycle each
//
// One byte leaves per cycle; the next item is taken in the cycle the CRC byte
// is being formed, so frames run back to back.
// A frequency item outside 5600..5800 is consumed with no output.
// The CRC is accumulated one byte per cycle as bytes are sent.
// rst_n is synchronous; it clears the frame and output valid flags.
// The receiver cannot stall: every byte is shown for exactly one cycle.
module vtx_command_framer
  import vcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_value,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);

  logic        active_r, active_nxt;
  idx_t        idx_r, idx_nxt;
  logic        cmd_r;
  logic [15:0] val_r;
  logic [7:0]  crc_r, crc_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        accept;
  logic        in_ok;
  logic [7:0]  cur_byte;

  assign busy   = active_r && (idx_r != IDX_CRC);
  assign accept = start && !busy;
  assign in_ok  = (in_command == CMD_POWER) ||
                  ((in_value >= FREQ_MIN) && (in_value <= FREQ_MAX));

  always_comb begin
    case (idx_r)
      3'd0:    cur_byte = SYNC_A;
      3'd1:    cur_byte = SYNC_B;
      3'd2:    cur_byte = (cmd_r == CMD_FREQ) ? OP_FREQ : OP_POWER;
      3'd3:    cur_byte = (cmd_r == CMD_FREQ) ? FREQ_PLD_LEN : POWER_PLD_LEN;
      3'd4:    cur_byte = (cmd_r == CMD_FREQ) ? val_r[15:8] : POWER_SUB;
      3'd5:    cur_byte = val_r[7:0];
      default: cur_byte = crc_r;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    if (accept) begin
      active_nxt = in_ok;
      idx_nxt    = '0;
      crc_nxt    = '0;
    end else if (active_r) begin
      if (idx_r == IDX_CRC) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_byte_r <= cur_byte;
    out_last_r <= active_r && (idx_r == IDX_CRC);
    if (accept) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last       = out_last_r;

endmodule

/* src/vtx_command_framer_checker.sv */
// vtx_command_framer_checker: port-level assertions on the command framer.
// Depends on vtx_command_framer_assert.svh and vcf_pkg; bound to vtx_command_framer.
`include "vtx_command_framer_assert.svh"

module vtx_command_framer_checker
  import vcf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_command,
  input logic        out_valid,
  input logic [7:0]  out_frame_byte,
  input logic        out_last
);

  `VCF_ASSERT(a_last_valid, clk, rst_n, out_last |-> out_valid, "last without valid")
  `VCF_ASSERT(a_frame_contig, clk, rst_n, (out_valid && !out_last) |=> out_valid, "frame gap")
  `VCF_ASSERT(a_power_sync, clk, rst_n, (start && !busy && (in_command == CMD_POWER)) |=> ##1 (out_valid && (out_frame_byte == SYNC_A)), "power item did not start frame")
  `VCF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind vtx_command_framer vtx_command_framer_checker u_vcf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_frame_byte (out_frame_byte),
  .out_last       (out_last)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb.sv: self-checking bench for vtx_command_framer. Drives power and frequency commands,
// predicts each framed packet with its CRC-8 and checks every byte. Depends on vcf_pkg and the RTL.
module tb;
  import vcf_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic        cmd;
    logic [15:0] value;
    logic        drain;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_command = 1'b0;
  logic [15:0] in_value = 16'h0000;
  logic        out_valid;
  logic [7:0]  out_frame_byte;
  logic        out_last;

  cmd_item_t   cmd_queue[$];
  frame_byte_t expected_bytes[$];

  int errors = 0;
  int cycles = 0;
  int items_taken = 0;
  int power_frames = 0;
  int freq_frames = 0;
  int freq_dropped = 0;
  int bytes_checked = 0;
  bit taken = 1'b0;

  always #5 clk = ~clk;

  vtx_command_framer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

  function automatic logic [7:0] crc8_d5(logic [7:0] crc, logic [7:0] data);
    crc = crc ^ data;
    repeat (8) begin
      if (crc[7]) begin
        crc = (crc << 1) ^ 8'hD5;
      end else begin
        crc = crc << 1;
      end
    end
    return crc;
  endfunction

  // queues the bytes one command should produce; out-of-range frequency gives none
  function automatic void predict_frame(logic cmd, logic [15:0] value);
    logic [7:0] frame_bytes [FRAME_LEN];
    logic [7:0] crc;
    if (cmd == CMD_FREQ && (value < FREQ_MIN || value > FREQ_MAX)) begin
      freq_dropped++;
      return;
    end
    frame_bytes[0] = SYNC_A;
    frame_bytes[1] = SYNC_B;
    if (cmd == CMD_POWER) begin
      frame_bytes[2] = OP_POWER;
      frame_bytes[3] = POWER_PLD_LEN;
      frame_bytes[4] = POWER_SUB;
      power_frames++;
    end else begin
      frame_bytes[2] = OP_FREQ;
      frame_bytes[3] = FREQ_PLD_LEN;
      frame_bytes[4] = value[15:8];
      freq_frames++;
    end
    frame_bytes[5] = value[7:0];
    crc = 8'h00;
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      crc = crc8_d5(crc, frame_bytes[k]);
    end
    frame_bytes[FRAME_LEN - 1] = crc;
    for (int k = 0; k < FRAME_LEN; k++) begin
      expected_bytes.push_back(frame_byte_t'{frame_bytes[k], k == FRAME_LEN - 1});
    end
  endfunction

  function automatic void add_cmd(logic cmd, logic [15:0] value, logic drain);
    cmd_queue.push_back(cmd_item_t'{cmd, value, drain});
  endfunction

  // result check, then capture of the accepted item
  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual %h last %b",
                   $time, out_frame_byte, out_last);
        end else begin
          exp_b = expected_bytes.pop_front();
          bytes_checked++;
          if (out_frame_byte !== exp_b.data) begin
            errors++;
            $display("%0t: frame_byte mismatch: expected %h, actual %h",
                     $time, exp_b.data, out_frame_byte);
          end
          if (out_last !== exp_b.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, exp_b.last, out_last);
          end
        end
      end
      if (start && !busy) begin
        predict_frame(in_command, in_value);
        items_taken++;
        taken <= 1'b1;
      end else begin
        taken <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // driver: no idling while items 200..279 go out
  always @(negedge clk) begin
    cmd_item_t nxt;
    bit burst;
    burst = items_taken >= 200 && items_taken < 280;
    if (rst_n) begin
      if (start && !taken) begin
        start <= 1'b1;
      end else if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_queue[0].drain && expected_bytes.size() != 0) begin
        start <= 1'b0;
      end else if (!burst && $urandom_range(99) < 34) begin
        start      <= 1'b0;
        in_command <= 1'($urandom_range(1));
        in_value   <= 16'($urandom_range(16'hFFFF));
      end else begin
        nxt = cmd_queue.pop_front();
        start      <= 1'b1;
        in_command <= nxt.cmd;
        in_value   <= nxt.value;
      end
    end
  end

  initial begin
    int r;
    add_cmd(CMD_POWER, 16'h0000, 1'b0);
    add_cmd(CMD_POWER, 16'h0001, 1'b0);
    add_cmd(CMD_POWER, 16'h0080, 1'b0);
    add_cmd(CMD_POWER, 16'h00FF, 1'b0);
    add_cmd(CMD_POWER, 16'h0100, 1'b0);
    add_cmd(CMD_POWER, 16'hFFFF, 1'b0);
    add_cmd(CMD_POWER, 16'hA55A, 1'b0);
    add_cmd(CMD_FREQ, 16'd5599, 1'b0);
    add_cmd(CMD_FREQ, 16'd5600, 1'b0);
    add_cmd(CMD_FREQ, 16'd5601, 1'b0);
    add_cmd(CMD_FREQ, 16'd5700, 1'b0);
    add_cmd(CMD_FREQ, 16'd5799, 1'b0);
    add_cmd(CMD_FREQ, 16'd5800, 1'b0);
    add_cmd(CMD_FREQ, 16'd5801, 1'b0);
    add_cmd(CMD_FREQ, 16'h0000, 1'b0);
    add_cmd(CMD_FREQ, 16'hFFFF, 1'b0);
    add_cmd(CMD_FREQ, 16'h5A5A, 1'b0);
    add_cmd(CMD_POWER, 16'h7F00, 1'b0);
    add_cmd(CMD_FREQ, 16'd5800, 1'b1);
    add_cmd(CMD_FREQ, 16'd5000, 1'b0);
    add_cmd(CMD_FREQ, 16'd6000, 1'b0);
    add_cmd(CMD_POWER, 16'h00C3, 1'b0);
    for (int n = 0; n < 350; n++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        add_cmd(CMD_POWER, 16'($urandom_range(16'hFFFF)), n == 120 || n == 300);
      end else if (r < 75) begin
        add_cmd(CMD_FREQ, 16'($urandom_range(5800, 5600)), n == 120 || n == 300);
      end else if (r < 85) begin
        add_cmd(CMD_FREQ, 16'($urandom_range(1) ? $urandom_range(5610, 5590)
                                                : $urandom_range(5810, 5790)),
                n == 120 || n == 300);
      end else begin
        add_cmd(CMD_FREQ, 16'($urandom_range(16'hFFFF)), n == 120 || n == 300);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || start || expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
    end
    $display("covered %0d commands: %0d power frames, %0d frequency frames,",
             items_taken, power_frames, freq_frames);
    $display("%0d out-of-range frequency commands dropped, %0d bytes checked",
             freq_dropped, bytes_checked);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/vcf_pkg.sv
src/vtx_command_framer.sv
src/vtx_command_framer_checker.sv
verif/tb.sv
